// ----- hw/rtl/csr_spmv_pkg.sv -----
// Shared constants, codes and request/result types for the CSR sparse matrix-vector block.
// No dependencies; every other file of the block imports this package.
package csr_spmv_pkg;

	localparam int MAX_ROWS     = 256;
	localparam int MAX_COLUMNS  = 256;
	localparam int MAX_NONZEROS = 4096;
	localparam int FRAC_BITS    = 16;

	localparam int CMD_W    = 2;
	localparam int SLOT_W   = 12;
	localparam int PTR_W    = 13;
	localparam int COL_W    = 8;
	localparam int DATA_W   = 32;
	localparam int CFG_W    = 9;
	localparam int ROWNUM_W = 8;
	localparam int STATUS_W = 2;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int ACC_W    = 64;

	localparam int PTR_IDX_W = $clog2(MAX_ROWS + 1);
	localparam int NZ_IDX_W  = $clog2(MAX_NONZEROS);
	localparam int VEC_IDX_W = $clog2(MAX_COLUMNS);

	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

	localparam logic [CMD_W-1:0] CMD_LOAD_PTR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_NZ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_VEC = 2'd2;
	localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd3;

	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		OP_LOAD_PTR,
		OP_LOAD_NZ,
		OP_LOAD_VEC,
		OP_COMPUTE,
		OP_BAD_ROW
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_SAT     = 2'd1,
		ST_BAD_ROW = 2'd2,
		ST_BAD_COL = 2'd3
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [SLOT_W-1:0]  slot;
		logic [PTR_W-1:0]   row_start;
		logic [COL_W-1:0]   column;
		logic [DATA_W-1:0]  operand;
	} req_t;

	typedef struct packed {
		logic [ROWNUM_W-1:0] row_number;
		logic [DATA_W-1:0]   row_result;
		status_t             status;
	} res_t;

endpackage

// ----- hw/rtl/csr_spmv_front.sv -----
// Front end: accepts input requests and classifies them into queue operations.
// Depends on csr_spmv_pkg; feeds csr_spmv_cmdq.
module csr_spmv_front (
	input  logic                              push,
	input  logic                              q_full,
	input  logic [csr_spmv_pkg::CMD_W-1:0]    command,
	input  logic [csr_spmv_pkg::SLOT_W-1:0]   slot,
	input  logic [csr_spmv_pkg::PTR_W-1:0]    row_start,
	input  logic [csr_spmv_pkg::COL_W-1:0]    column,
	input  logic [csr_spmv_pkg::DATA_W-1:0]   operand,
	input  logic [csr_spmv_pkg::CFG_W-1:0]    rows,
	output csr_spmv_pkg::req_t                req,
	output logic                              q_push
);
	import csr_spmv_pkg::*;

	logic keep;

	always_comb begin
		req.slot      = slot;
		req.row_start = row_start;
		req.column    = column;
		req.operand   = operand;
		req.op        = OP_LOAD_PTR;
		keep          = 1'b0;
		case (command)
			CMD_LOAD_PTR: begin
				req.op = OP_LOAD_PTR;
				keep   = 32'(slot) < MAX_ROWS + 1;
			end
			CMD_LOAD_NZ: begin
				req.op = OP_LOAD_NZ;
				keep   = 32'(slot) < MAX_NONZEROS;
			end
			CMD_LOAD_VEC: begin
				req.op = OP_LOAD_VEC;
				keep   = 32'(slot) < MAX_COLUMNS;
			end
			CMD_COMPUTE: begin
				req.op = (32'(slot) < 32'(rows)) ? OP_COMPUTE : OP_BAD_ROW;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// drop out-of-range loads
	assign q_push = push && !q_full && keep;

endmodule

// ----- hw/rtl/csr_spmv_cmdq.sv -----
// Request queue between the front end and the compute back end.
// Depends on csr_spmv_pkg.
module csr_spmv_cmdq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csr_spmv_pkg::req_t din,
	input  logic               pop,
	output csr_spmv_pkg::req_t dout,
	output logic               full,
	output logic               empty
);
	import csr_spmv_pkg::*;

	localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	req_t          entry_q [CMDQ_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(CMDQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/csr_spmv_resq.sv -----
// Result queue between the compute back end and the output port.
// Depends on csr_spmv_pkg.
module csr_spmv_resq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csr_spmv_pkg::res_t din,
	input  logic               pop,
	output csr_spmv_pkg::res_t dout,
	output logic               full,
	output logic               empty
);
	import csr_spmv_pkg::*;

	localparam int AW = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int CW = $clog2(RESQ_DEPTH + 1);

	res_t          entry_q [RESQ_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(RESQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(RESQ_DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(RESQ_DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/csr_spmv_back.sv -----
// Back end: matrix and vector memories, row walk and multiply-accumulate pipe.
// Depends on csr_spmv_pkg; pops csr_spmv_cmdq and pushes csr_spmv_resq.
module csr_spmv_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [csr_spmv_pkg::CFG_W-1:0] cols,
	input  csr_spmv_pkg::req_t             req,
	input  logic                           req_valid,
	output logic                           req_pop,
	output csr_spmv_pkg::res_t             res,
	output logic                           res_push,
	input  logic                           res_full
);
	import csr_spmv_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PTR_A,
		S_PTR_B,
		S_WALK,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;

	logic [PTR_W-1:0]  ptr_mem [MAX_ROWS + 1];
	logic [COL_W-1:0]  col_mem [MAX_NONZEROS];
	logic [DATA_W-1:0] val_mem [MAX_NONZEROS];
	logic [DATA_W-1:0] vec_mem [MAX_COLUMNS];

	logic [PTR_IDX_W-1:0]     ptr_raddr;
	logic [PTR_W-1:0]         ptr_rd_q;
	logic [COL_W-1:0]         col_s1;
	logic signed [DATA_W-1:0] val_s1;
	logic signed [DATA_W-1:0] val_s2;
	logic signed [DATA_W-1:0] vec_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;

	logic [SLOT_W-1:0] slot_q;
	logic              ptr_bad_q;
	logic              col_bad_q;
	logic [PTR_W-1:0]  first_q;
	logic [PTR_W-1:0]  last_q;
	logic [PTR_W-1:0]  idx_q;
	logic [ACC_W-1:0]  acc_q;

	logic take;
	logic ptr_we;
	logic nz_we;
	logic vec_we;
	logic sat;

	assign take      = (state_q == S_IDLE) && req_valid;
	assign req_pop   = take;
	assign ptr_we    = take && (req.op == OP_LOAD_PTR);
	assign nz_we     = take && (req.op == OP_LOAD_NZ);
	assign vec_we    = take && (req.op == OP_LOAD_VEC);
	assign ptr_raddr = (state_q == S_IDLE) ? req.slot[PTR_IDX_W-1:0]
	                                       : slot_q[PTR_IDX_W-1:0] + PTR_IDX_W'(1);

	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[req.slot[PTR_IDX_W-1:0]] <= req.row_start;
		end
		ptr_rd_q <= ptr_mem[ptr_raddr];
	end

	always_ff @(posedge clk) begin
		if (nz_we) begin
			col_mem[req.slot[NZ_IDX_W-1:0]] <= req.column;
			val_mem[req.slot[NZ_IDX_W-1:0]] <= req.operand;
		end
		col_s1 <= col_mem[idx_q[NZ_IDX_W-1:0]];
		val_s1 <= val_mem[idx_q[NZ_IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[req.slot[VEC_IDX_W-1:0]] <= req.operand;
		end
		vec_s2 <= vec_mem[col_s1[VEC_IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		val_s2  <= val_s1;
		prod_s3 <= val_s2 * vec_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			slot_q    <= '0;
			ptr_bad_q <= 1'b0;
			col_bad_q <= 1'b0;
			first_q   <= '0;
			last_q    <= '0;
			idx_q     <= '0;
			acc_q     <= '0;
		end else begin
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s1 && (CFG_W'(col_s1) >= cols)) begin
				col_bad_q <= 1'b1;
			end
			if (v_s3) begin
				acc_q <= acc_q + ACC_W'(prod_s3 >>> FRAC_BITS);
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						slot_q <= req.slot;
						case (req.op)
							OP_COMPUTE: begin
								ptr_bad_q <= 1'b0;
								state_q   <= S_PTR_A;
							end
							OP_BAD_ROW: begin
								ptr_bad_q <= 1'b1;
								state_q   <= S_FINISH;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PTR_A: begin
					first_q <= ptr_rd_q;
					state_q <= S_PTR_B;
				end
				S_PTR_B: begin
					acc_q     <= '0;
					col_bad_q <= 1'b0;
					idx_q     <= first_q;
					last_q    <= ptr_rd_q;
					if ((first_q > ptr_rd_q) || (32'(ptr_rd_q) > MAX_NONZEROS)) begin
						ptr_bad_q <= 1'b1;
						state_q   <= S_FINISH;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (idx_q < last_q) begin
						v_s1  <= 1'b1;
						idx_q <= idx_q + PTR_W'(1);
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign sat      = !((&acc_q[ACC_W-1:DATA_W-1]) || !(|acc_q[ACC_W-1:DATA_W-1]));
	assign res_push = (state_q == S_FINISH) && !res_full;

	always_comb begin
		res.row_number = slot_q[ROWNUM_W-1:0];
		if (ptr_bad_q) begin
			res.status     = ST_BAD_ROW;
			res.row_result = '0;
		end else if (col_bad_q) begin
			res.status     = ST_BAD_COL;
			res.row_result = '0;
		end else if (sat) begin
			res.status     = ST_SAT;
			res.row_result = acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX;
		end else begin
			res.status     = ST_OK;
			res.row_result = acc_q[DATA_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/csr_sparse_matrix_vector_multiply.sv -----
// Top level of the CSR sparse matrix-vector block: config registers, front end, request
// queue, back end and result queue. Depends on csr_spmv_pkg and csr_spmv_front/cmdq/back/resq.
//
//   channel   handshake            payload
//   input     push / full          command, slot, row_start, column, operand
//   result    empty / pop          row_number, row_result, status
//   config    wr_en                wr_index, wr_data
//
// A load request is written to its memory as the back end pops it. A compute request reads
// its row pointers and walks its nonzeros through the single read port of the nonzero memory
// and the three-stage read/multiply/accumulate pipe; a bad row goes straight to its result.
// Reset clears config registers, queues and control; memories hold garbage until loaded.
// full stalls only when the request queue is full; a stalled result holds the back end
// once the result queue is full.
module csr_sparse_matrix_vector_multiply (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [csr_spmv_pkg::CMD_W-1:0]     command,
	input  logic [csr_spmv_pkg::SLOT_W-1:0]    slot,
	input  logic [csr_spmv_pkg::PTR_W-1:0]     row_start,
	input  logic [csr_spmv_pkg::COL_W-1:0]     column,
	input  logic signed [csr_spmv_pkg::DATA_W-1:0] operand,
	output logic                               empty,
	input  logic                               pop,
	output logic [csr_spmv_pkg::ROWNUM_W-1:0]  row_number,
	output logic signed [csr_spmv_pkg::DATA_W-1:0] row_result,
	output logic [csr_spmv_pkg::STATUS_W-1:0]  status,
	input  logic                               wr_en,
	input  logic [csr_spmv_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [csr_spmv_pkg::CFG_W-1:0]     wr_data
);
	import csr_spmv_pkg::*;

	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] column_count_q;
	logic [CFG_W-1:0] rows;
	logic [CFG_W-1:0] cols;

	req_t fe_req;
	logic fe_push;
	req_t q_req;
	logic q_full;
	logic q_empty;
	logic q_pop;
	res_t be_res;
	logic be_push;
	logic r_full;
	res_t r_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= '0;
			column_count_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROW_COUNT:    row_count_q    <= wr_data;
				REG_COLUMN_COUNT: column_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign rows = (row_count_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : row_count_q;
	assign cols = (column_count_q > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : column_count_q;

	csr_spmv_front u_front (
		.push      (push),
		.q_full    (q_full),
		.command   (command),
		.slot      (slot),
		.row_start (row_start),
		.column    (column),
		.operand   (operand),
		.rows      (rows),
		.req       (fe_req),
		.q_push    (fe_push)
	);

	csr_spmv_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.din    (fe_req),
		.pop    (q_pop),
		.dout   (q_req),
		.full   (q_full),
		.empty  (q_empty)
	);

	csr_spmv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cols      (cols),
		.req       (q_req),
		.req_valid (!q_empty),
		.req_pop   (q_pop),
		.res       (be_res),
		.res_push  (be_push),
		.res_full  (r_full)
	);

	csr_spmv_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (be_push),
		.din    (be_res),
		.pop    (pop),
		.dout   (r_head),
		.full   (r_full),
		.empty  (empty)
	);

	assign full       = q_full;
	assign row_number = r_head.row_number;
	assign row_result = r_head.row_result;
	assign status     = r_head.status;

endmodule

// ----- hw/rtl/csr_spmv_chk.sv -----
// Port-level checker for csr_sparse_matrix_vector_multiply and its bind statement.
// Depends on csr_spmv_pkg.
module csr_spmv_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               full,
	input logic                               empty,
	input logic                               pop,
	input logic [csr_spmv_pkg::ROWNUM_W-1:0]  row_number,
	input logic [csr_spmv_pkg::DATA_W-1:0]    row_result,
	input logic [csr_spmv_pkg::STATUS_W-1:0]  status
);
	import csr_spmv_pkg::*;

	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not clear in reset");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_BAD_ROW || status == ST_BAD_COL)) |-> (row_result == '0))
		else $error("error result carries a nonzero value");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_SAT) |-> (row_result == SAT_MAX || row_result == SAT_MIN))
		else $error("saturated result not at a bound");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(row_result) && $stable(status)
			&& $stable(row_number)))
		else $error("waiting result changed");

endmodule

bind csr_sparse_matrix_vector_multiply csr_spmv_chk u_chk (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for csr_sparse_matrix_vector_multiply: builds CSR rows, computes them
// under several row/column counts and checks every result against a built-in row-product model.
// Depends on csr_spmv_pkg and the block's RTL.
module testbench;
	import csr_spmv_pkg::*;

	localparam int TAIL_CYCLES = 64;
	localparam int LONG_HOLD = 300;
	localparam int PHASE_ITEMS = 170;
	localparam int SLOT_TOP = (1 << SLOT_W) - 1;

	class row_product_board;
		logic [PTR_W-1:0]  row_ptr [MAX_ROWS+1];
		logic [COL_W-1:0]  nz_col [MAX_NONZEROS];
		logic [DATA_W-1:0] nz_val [MAX_NONZEROS];
		logic [DATA_W-1:0] vec [MAX_COLUMNS];
		bit ptr_set [MAX_ROWS+1];
		bit nz_set [MAX_NONZEROS];
		bit vec_set [MAX_COLUMNS];
		int unsigned rows;
		int unsigned cols;
		res_t expected_rows [$];
		int errors;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			if (idx == REG_ROW_COUNT)
				rows = d;
			else if (idx == REG_COLUMN_COUNT)
				cols = d;
		endfunction

		function int unsigned eff_rows();
			return (rows > MAX_ROWS) ? MAX_ROWS : rows;
		endfunction

		function int unsigned eff_cols();
			return (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
		endfunction

		function bit row_readable(int unsigned r);
			int unsigned first, last, i;
			if (r >= eff_rows())
				return 1;
			if (!ptr_set[r] || !ptr_set[r+1])
				return 0;
			first = row_ptr[r];
			last = row_ptr[r+1];
			if (first > last || last > MAX_NONZEROS)
				return 1;
			for (i = first; i < last; i++) begin
				if (!nz_set[i])
					return 0;
				if (nz_col[i] < eff_cols() && !vec_set[nz_col[i]])
					return 0;
			end
			return 1;
		endfunction

		function res_t predict_row(int unsigned r);
			res_t want;
			status_t st;
			longint acc, prod;
			int unsigned first, last, i;
			acc = 0;
			st = ST_OK;
			want.row_number = r[ROWNUM_W-1:0];
			want.row_result = '0;
			if (r >= eff_rows()) begin
				st = ST_BAD_ROW;
			end else begin
				first = row_ptr[r];
				last = row_ptr[r+1];
				if (first > last || last > MAX_NONZEROS) begin
					st = ST_BAD_ROW;
				end else begin
					for (i = first; i < last && st == ST_OK; i++) begin
						if (nz_col[i] >= eff_cols()) begin
							st = ST_BAD_COL;
						end else begin
							prod = longint'(signed'(nz_val[i])) * longint'(signed'(vec[nz_col[i]]));
							acc += prod >>> FRAC_BITS;
						end
					end
				end
			end
			if (st == ST_OK) begin
				if (acc > 64'sd2147483647) begin
					want.row_result = SAT_MAX;
					st = ST_SAT;
				end else if (acc < -64'sd2147483648) begin
					want.row_result = SAT_MIN;
					st = ST_SAT;
				end else begin
					want.row_result = acc[DATA_W-1:0];
				end
			end
			want.status = st;
			return want;
		endfunction

		function bit note_request(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] s,
				logic [PTR_W-1:0] p, logic [COL_W-1:0] col, logic [DATA_W-1:0] d);
			case (c)
				CMD_LOAD_PTR: begin
					if (s > MAX_ROWS)
						return 0;
					row_ptr[s] = p;
					ptr_set[s] = 1;
				end
				CMD_LOAD_NZ: begin
					if (s >= MAX_NONZEROS)
						return 0;
					nz_col[s] = col;
					nz_val[s] = d;
					nz_set[s] = 1;
				end
				CMD_LOAD_VEC: begin
					if (s >= MAX_COLUMNS)
						return 0;
					vec[s] = d;
					vec_set[s] = 1;
				end
				default: expected_rows.push_back(predict_row(s));
			endcase
			return 1;
		endfunction

		function void check_result(logic [ROWNUM_W-1:0] rn, logic [DATA_W-1:0] rv,
				logic [STATUS_W-1:0] st);
			res_t want;
			if (expected_rows.size() == 0) begin
				$error("result for row %0d arrived with no request outstanding", rn);
				errors++;
				return;
			end
			want = expected_rows.pop_front();
			if (rn !== want.row_number) begin
				$error("row_number: expected %0d, got %0d", want.row_number, rn);
				errors++;
			end
			if (rv !== want.row_result) begin
				$error("row_result: expected %08h, got %08h", want.row_result, rv);
				errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic [CMD_W-1:0]            command;
	logic [SLOT_W-1:0]           slot;
	logic [PTR_W-1:0]            row_start;
	logic [COL_W-1:0]            column;
	logic signed [DATA_W-1:0]    operand;
	logic                        empty;
	logic                        pop;
	logic [ROWNUM_W-1:0]         row_number;
	logic signed [DATA_W-1:0]    row_result;
	logic [STATUS_W-1:0]         status;
	logic                        wr_en;
	logic [CFG_IDX_W-1:0]        wr_index;
	logic [CFG_W-1:0]            wr_data;

	row_product_board sb;
	int send_calm;
	int items_done;

	csr_sparse_matrix_vector_multiply uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			calm = $urandom_range(20, 60);
		case ($urandom_range(0, 19))
			0: return $urandom_range(20, 60);
			1, 2: return $urandom_range(4, 12);
			3, 4, 5, 6, 7: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1, 2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: begin
				case ($urandom_range(0, 3))
					0: return SAT_MAX;
					1: return SAT_MIN;
					2: return '0;
					default: return 32'h0001_0000;
				endcase
			end
		endcase
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic [PTR_W-1:0] p, input logic [COL_W-1:0] col,
			input logic [DATA_W-1:0] d);
		int gap;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		command <= c;
		slot <= s;
		row_start <= p;
		column <= col;
		operand <= d;
		do @(posedge clk); while (full);
		if (sb.note_request(c, s, p, col, d))
			items_done++;
	endtask

	task automatic send_compute(input int unsigned r);
		if (!sb.row_readable(r))
			r = $urandom_range(MAX_ROWS + 1, SLOT_TOP);
		send_request(CMD_COMPUTE, SLOT_W'(r), PTR_W'($urandom_range(0, MAX_NONZEROS)),
			COL_W'($urandom), $urandom);
	endtask

	task automatic send_ptr(input int unsigned s, input int unsigned p);
		send_request(CMD_LOAD_PTR, SLOT_W'(s), PTR_W'(p), COL_W'($urandom), $urandom);
	endtask

	task automatic send_nz(input int unsigned s, input int unsigned col, input logic [DATA_W-1:0] d);
		send_request(CMD_LOAD_NZ, SLOT_W'(s), PTR_W'($urandom_range(0, MAX_NONZEROS)),
			COL_W'(col), d);
	endtask

	task automatic send_vec(input int unsigned s, input logic [DATA_W-1:0] d);
		send_request(CMD_LOAD_VEC, SLOT_W'(s), PTR_W'($urandom_range(0, MAX_NONZEROS)),
			COL_W'($urandom), d);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
		wr_en <= 1'b1;
		wr_index <= REG_ROW_COUNT;
		wr_data <= rows_val;
		@(posedge clk);
		sb.write_reg(REG_ROW_COUNT, rows_val);
		wr_index <= REG_COLUMN_COUNT;
		wr_data <= cols_val;
		@(posedge clk);
		sb.write_reg(REG_COLUMN_COUNT, cols_val);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.expected_rows.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic build_row();
		int unsigned r, n, p0, p1, rows_now, cols_now, i;
		int unsigned cols_q [$];
		rows_now = sb.eff_rows();
		cols_now = sb.eff_cols();
		if (rows_now > 0 && $urandom_range(0, 9) != 0)
			r = $urandom_range(0, rows_now - 1);
		else
			r = $urandom_range(0, MAX_ROWS);
		case ($urandom_range(0, 19))
			0: n = $urandom_range(40, 200);
			1: n = 0;
			default: n = $urandom_range(1, 10);
		endcase
		p0 = $urandom_range(0, MAX_NONZEROS - n);
		p1 = p0 + n;
		if ($urandom_range(0, 11) == 0) begin
			p0 = $urandom_range(1, MAX_NONZEROS);
			p1 = $urandom_range(0, p0 - 1);
		end
		send_ptr(r, p0);
		send_ptr(r + 1, p1);
		for (i = p0; i < p1; i++) begin
			if (cols_now == 0 || $urandom_range(0, 14) == 0)
				cols_q.push_back($urandom_range(0, MAX_COLUMNS - 1));
			else
				cols_q.push_back($urandom_range(0, cols_now - 1));
		end
		foreach (cols_q[k])
			if (cols_q[k] < cols_now && (!sb.vec_set[cols_q[k]] || $urandom_range(0, 3) == 0))
				send_vec(cols_q[k], pick_value());
		foreach (cols_q[k])
			send_nz(p0 + k, cols_q[k], pick_value());
		send_compute(r);
	endtask

	task automatic noise_item();
		int unsigned s;
		s = $urandom_range(0, SLOT_TOP);
		case ($urandom_range(0, 3))
			0: begin
				if ($urandom_range(0, 1))
					s = $urandom_range(0, MAX_ROWS);
				send_ptr(s, $urandom_range(0, MAX_NONZEROS));
			end
			1: send_nz(s, $urandom_range(0, MAX_COLUMNS - 1), pick_value());
			2: begin
				if ($urandom_range(0, 1))
					s = $urandom_range(0, MAX_COLUMNS - 1);
				send_vec(s, pick_value());
			end
			default: send_compute($urandom_range(0, MAX_ROWS));
		endcase
	endtask

	task automatic directed_rows();
		send_vec(0, SAT_MAX);
		send_vec(MAX_COLUMNS - 1, SAT_MIN);
		send_vec(1, 32'h0001_0000);
		send_ptr(0, 0);
		send_ptr(1, 3);
		send_ptr(2, 3);
		send_nz(0, 0, SAT_MAX);
		send_nz(1, MAX_COLUMNS - 1, SAT_MIN);
		send_nz(2, 1, 32'h0001_0000);
		send_compute(0);
		send_compute(1);
		send_ptr(MAX_ROWS - 1, MAX_NONZEROS - 2);
		send_ptr(MAX_ROWS, MAX_NONZEROS);
		send_nz(MAX_NONZEROS - 2, 1, 32'hFFFF_0000);
		send_nz(MAX_NONZEROS - 1, 1, 32'h0000_8000);
		send_compute(MAX_ROWS - 1);
		send_compute(MAX_ROWS);
		send_compute(SLOT_TOP);
		send_ptr(2, 5);
		send_ptr(3, 4);
		send_ptr(4, 5);
		send_nz(4, MAX_COLUMNS - 1, SAT_MAX);
		send_compute(2);
		send_compute(3);
	endtask

	initial begin
		int unsigned phase_rows [6];
		int unsigned phase_cols [6];
		phase_rows = '{MAX_ROWS, 1, 0, 0, MAX_ROWS, MAX_ROWS - 1};
		phase_cols = '{MAX_COLUMNS, 1, 0, 0, 16, MAX_COLUMNS - 1};
		phase_rows[3] = $urandom_range(2, MAX_ROWS);
		phase_cols[3] = $urandom_range(2, MAX_COLUMNS);
		sb = new();
		send_calm = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		command <= CMD_LOAD_PTR;
		slot <= '0;
		row_start <= '0;
		column <= '0;
		operand <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_ROW_COUNT;
		wr_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 6; p++) begin
			if (p > 0)
				drain();
			set_config(CFG_W'(phase_rows[p]), CFG_W'(phase_cols[p]));
			if (p == 0)
				directed_rows();
			items_done = 0;
			while (items_done < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) != 0)
					build_row();
				else
					noise_item();
			end
		end
		drain();
		if (sb.errors == 0)
			$display("** csr_sparse_matrix_vector_multiply: PASSED **");
		else
			$display("** csr_sparse_matrix_vector_multiply: FAILED **");
		$finish;
	end

	initial begin
		int gap, taken, calm;
		taken = 0;
		calm = 0;
		pop <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			gap = pick_gap(calm);
			if (taken == 20 || taken == 100)
				gap = LONG_HOLD;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(row_number, row_result, status);
			taken++;
		end
	end

	initial begin
		#20_000_000;
		$display("** csr_sparse_matrix_vector_multiply: FAILED **");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/csr_spmv_pkg.sv
hw/rtl/csr_spmv_front.sv
hw/rtl/csr_spmv_cmdq.sv
hw/rtl/csr_spmv_resq.sv
hw/rtl/csr_spmv_back.sv
hw/rtl/csr_sparse_matrix_vector_multiply.sv
hw/rtl/csr_spmv_chk.sv
sim/testbench.sv
